[src/pzfr_pkg.sv]
package pzfr_pkg;

    localparam int MAX_ZEROS = 32;
    localparam int MAX_POLES = 32;
    localparam int MAX_ROOTS = (MAX_ZEROS > MAX_POLES) ? MAX_ZEROS : MAX_POLES;
    localparam int ZA_W      = (MAX_ZEROS > 1) ? $clog2(MAX_ZEROS) : 1;
    localparam int PA_W      = (MAX_POLES > 1) ? $clog2(MAX_POLES) : 1;
    localparam int CNT_W     = $clog2(MAX_ROOTS + 1);

    localparam logic [31:0] TWO_PI_Q29 = 32'hC90FDAA2;

    localparam int DVD_W = 64;
    localparam int DSR_W = 34;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TUSER_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ZEROS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_POLES = 2'd3;

    localparam logic [2:0] STEP_0 = 3'd0;
    localparam logic [2:0] STEP_1 = 3'd1;
    localparam logic [2:0] STEP_2 = 3'd2;
    localparam logic [2:0] STEP_3 = 3'd3;
    localparam logic [2:0] STEP_4 = 3'd4;
    localparam logic [2:0] STEP_5 = 3'd5;

    typedef enum logic [1:0] {
        OP_LOAD_ZERO = 2'd0,
        OP_LOAD_POLE = 2'd1,
        OP_EVAL      = 2'd2
    } pzfr_op_t;

    typedef struct packed {
        logic       wr_zero;
        logic       wr_pole;
        logic       cap_eval;
        logic       omega_mul;
        logic       omega_rnd;
        logic       tab_sel;
        logic       prod_init;
        logic       save_num;
        logic       rd_issue;
        logic       fac_load;
        logic       mac_en;
        logic       mac_div;
        logic [2:0] mac_step;
        logic       norm_len;
        logic       norm_calc;
        logic       norm_apply;
        logic       div_start;
        logic       part_sel;
        logic       scale_mul;
        logic       scale_sat;
        logic       out_load;
        logic       out_zden;
    } pzfr_cmd_t;

    typedef struct packed {
        logic cnt_done;
        logic zero_den;
        logic div_done;
        logic out_free;
    } pzfr_stat_t;

endpackage

[src/pzfr_div.sv]
module pzfr_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pzfr_pkg::DVD_W-1:0]  dividend,
    input  logic [pzfr_pkg::DSR_W-1:0]  divisor,
    output logic                        done,
    output logic [pzfr_pkg::DVD_W-1:0]  quotient
);

    localparam int IT_W = $clog2(pzfr_pkg::DVD_W + 1);

    logic [IT_W-1:0]               cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [pzfr_pkg::DVD_W-1:0]    dvd_reg;
    logic [pzfr_pkg::DSR_W-1:0]    rem_reg;
    logic [pzfr_pkg::DSR_W-1:0]    dsr_reg;
    logic [pzfr_pkg::DSR_W:0]      rem_sh;
    logic [pzfr_pkg::DSR_W+1:0]    diff;
    logic                          ge;

    assign rem_sh = {rem_reg, dvd_reg[pzfr_pkg::DVD_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dsr_reg};
    assign ge     = ~diff[pzfr_pkg::DSR_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + IT_W'(1);
            if (cnt_reg == IT_W'(pzfr_pkg::DVD_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[pzfr_pkg::DSR_W-1:0] : rem_sh[pzfr_pkg::DSR_W-1:0];
            dvd_reg <= {dvd_reg[pzfr_pkg::DVD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

[src/pzfr_ctrl.sv]
module pzfr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  pzfr_pkg::pzfr_op_t   opcode,
    input  pzfr_pkg::pzfr_stat_t stat,
    output logic                 s_tready,
    output pzfr_pkg::pzfr_cmd_t  cmd
);

    typedef enum logic [16:0] {
        S_IDLE       = 17'h00001,
        S_OMEGA_MUL  = 17'h00002,
        S_OMEGA_RND  = 17'h00004,
        S_INIT       = 17'h00008,
        S_CHECK      = 17'h00010,
        S_RD         = 17'h00020,
        S_FAC        = 17'h00040,
        S_MAC        = 17'h00080,
        S_NORM_LEN   = 17'h00100,
        S_NORM_CALC  = 17'h00200,
        S_NORM_APPLY = 17'h00400,
        S_PREP       = 17'h00800,
        S_DIV_START  = 17'h01000,
        S_DIV_WAIT   = 17'h02000,
        S_SCALE_MUL  = 17'h04000,
        S_SCALE_SAT  = 17'h08000,
        S_OUT        = 17'h10000
    } pzfr_state_t;

    pzfr_state_t state_reg, state_next;
    logic [2:0]  step_reg, step_next;
    logic        tab_sel_reg, tab_sel_next;
    logic        part_reg, part_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= pzfr_pkg::STEP_0;
            tab_sel_reg <= 1'b0;
            part_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            tab_sel_reg <= tab_sel_next;
            part_reg    <= part_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        tab_sel_next = tab_sel_reg;
        part_next    = part_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.tab_sel  = tab_sel_reg;
        cmd.part_sel = part_reg;
        cmd.mac_step = step_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (opcode)
                        pzfr_pkg::OP_LOAD_ZERO: cmd.wr_zero = 1'b1;
                        pzfr_pkg::OP_LOAD_POLE: cmd.wr_pole = 1'b1;
                        pzfr_pkg::OP_EVAL: begin
                            cmd.cap_eval = 1'b1;
                            state_next   = S_OMEGA_MUL;
                        end
                        default: ;
                    endcase
                end
            end
            S_OMEGA_MUL: begin
                cmd.omega_mul = 1'b1;
                state_next    = S_OMEGA_RND;
            end
            S_OMEGA_RND: begin
                cmd.omega_rnd = 1'b1;
                tab_sel_next  = 1'b0;
                state_next    = S_INIT;
            end
            S_INIT: begin
                cmd.prod_init = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK: begin
                if (stat.cnt_done) begin
                    if (!tab_sel_reg) begin
                        cmd.save_num = 1'b1;
                        tab_sel_next = 1'b1;
                        state_next   = S_INIT;
                    end else begin
                        step_next  = pzfr_pkg::STEP_0;
                        state_next = S_PREP;
                    end
                end else begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_FAC;
            end
            S_FAC: begin
                cmd.fac_load = 1'b1;
                step_next    = pzfr_pkg::STEP_0;
                state_next   = S_MAC;
            end
            S_MAC: begin
                cmd.mac_en = 1'b1;
                if (step_reg == pzfr_pkg::STEP_3) begin
                    state_next = S_NORM_LEN;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            S_NORM_LEN: begin
                cmd.norm_len = 1'b1;
                state_next   = S_NORM_CALC;
            end
            S_NORM_CALC: begin
                cmd.norm_calc = 1'b1;
                state_next    = S_NORM_APPLY;
            end
            S_NORM_APPLY: begin
                cmd.norm_apply = 1'b1;
                state_next     = S_CHECK;
            end
            S_PREP: begin
                cmd.mac_en  = 1'b1;
                cmd.mac_div = 1'b1;
                if (step_reg == pzfr_pkg::STEP_5) begin
                    part_next  = 1'b0;
                    state_next = stat.zero_den ? S_OUT : S_DIV_START;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            S_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (stat.div_done) state_next = S_SCALE_MUL;
            end
            S_SCALE_MUL: begin
                cmd.scale_mul = 1'b1;
                state_next    = S_SCALE_SAT;
            end
            S_SCALE_SAT: begin
                cmd.scale_sat = 1'b1;
                if (!part_reg) begin
                    part_next  = 1'b1;
                    state_next = S_DIV_START;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_zden = stat.zero_den;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

[src/pzfr_dp.sv]
module pzfr_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  pzfr_pkg::pzfr_cmd_t             cmd,
    output pzfr_pkg::pzfr_stat_t            stat,
    input  logic                            cfg_wr_en,
    input  logic [pzfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pzfr_pkg::CFG_DAT_W-1:0]  cfg_wr_data,
    input  logic [4:0]                      entry_index,
    input  logic [31:0]                     root_real,
    input  logic [31:0]                     root_imag,
    input  logic [15:0]                     freq_index,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pzfr_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [pzfr_pkg::M_TUSER_W-1:0]  m_tuser
);

    function automatic logic [63:0] rnd_mag(input logic [63:0] u, input logic [6:0] s);
        logic [63:0] r;
        if (s == 7'd0) r = u;
        else if (s >= 7'd64) r = '0;
        else r = (u >> s) + ((u >> (s - 7'd1)) & 64'd1);
        return r;
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] rnd_sgn(input logic [63:0] v, input logic [6:0] s);
        logic [63:0] r;
        r = rnd_mag(mag64(v), s);
        return v[63] ? (64'd0 - r) : r;
    endfunction

    // configuration
    logic [31:0] gain_reg;
    logic [31:0] freq_step_reg;
    logic [5:0]  num_zeros_reg;
    logic [5:0]  num_poles_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg      <= 32'd65536;
            freq_step_reg <= 32'd65536;
            num_zeros_reg <= '0;
            num_poles_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pzfr_pkg::CFG_GAIN:      gain_reg      <= cfg_wr_data;
                pzfr_pkg::CFG_FREQ_STEP: freq_step_reg <= cfg_wr_data;
                pzfr_pkg::CFG_NUM_ZEROS: num_zeros_reg <= cfg_wr_data[5:0];
                pzfr_pkg::CFG_NUM_POLES: num_poles_reg <= cfg_wr_data[5:0];
                default: ;
            endcase
        end
    end

    // root tables
    logic [63:0] zero_mem [pzfr_pkg::MAX_ZEROS];
    logic [63:0] pole_mem [pzfr_pkg::MAX_POLES];
    logic [63:0] zrd_reg, prd_reg;
    logic [pzfr_pkg::CNT_W-1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_zero && (int'(entry_index) < pzfr_pkg::MAX_ZEROS))
            zero_mem[pzfr_pkg::ZA_W'(entry_index)] <= {root_imag, root_real};
        if (cmd.rd_issue)
            zrd_reg <= zero_mem[cnt_reg[pzfr_pkg::ZA_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_pole && (int'(entry_index) < pzfr_pkg::MAX_POLES))
            pole_mem[pzfr_pkg::PA_W'(entry_index)] <= {root_imag, root_real};
        if (cmd.rd_issue)
            prd_reg <= pole_mem[cnt_reg[pzfr_pkg::PA_W-1:0]];
    end

    logic [pzfr_pkg::CNT_W-1:0] nz_lim, np_lim;
    assign nz_lim = (int'(num_zeros_reg) > pzfr_pkg::MAX_ZEROS) ?
                    pzfr_pkg::CNT_W'(pzfr_pkg::MAX_ZEROS) : pzfr_pkg::CNT_W'(num_zeros_reg);
    assign np_lim = (int'(num_poles_reg) > pzfr_pkg::MAX_POLES) ?
                    pzfr_pkg::CNT_W'(pzfr_pkg::MAX_POLES) : pzfr_pkg::CNT_W'(num_poles_reg);

    // omega
    logic [15:0] freq_idx_reg;
    logic [47:0] fk_reg;
    logic [31:0] omega_reg;
    logic [60:0] wprod;
    logic [31:0] wval;

    assign wprod = 61'(fk_reg[28:0]) * 61'(pzfr_pkg::TWO_PI_Q29) + 61'(64'd1 << 28);
    assign wval  = wprod[60:29];

    // running product
    logic signed [30:0] mr_reg, mi_reg, nr_reg, ni_reg;
    logic [15:0]        exp_reg, en_reg;
    logic signed [33:0] fr_reg, fi_reg;
    logic [63:0]        acc_r_reg, acc_i_reg, den_reg;
    logic [63:0]        m_reg;
    logic [6:0]         blen_reg, s_reg;
    logic               right_reg, nzero_reg;
    logic [63:0]        rd_sel;

    assign rd_sel = cmd.tab_sel ? prd_reg : zrd_reg;

    logic signed [30:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [64:0] mul_p;
    logic [63:0]        p64;

    always_comb begin
        mul_a = mr_reg;
        mul_b = fr_reg;
        if (!cmd.mac_div) begin
            unique case (cmd.mac_step)
                pzfr_pkg::STEP_0: begin mul_a = mr_reg; mul_b = fr_reg; end
                pzfr_pkg::STEP_1: begin mul_a = mi_reg; mul_b = fi_reg; end
                pzfr_pkg::STEP_2: begin mul_a = mr_reg; mul_b = fi_reg; end
                pzfr_pkg::STEP_3: begin mul_a = mi_reg; mul_b = fr_reg; end
                default: ;
            endcase
        end else begin
            unique case (cmd.mac_step)
                pzfr_pkg::STEP_0: begin mul_a = nr_reg; mul_b = 34'(mr_reg); end
                pzfr_pkg::STEP_1: begin mul_a = ni_reg; mul_b = 34'(mi_reg); end
                pzfr_pkg::STEP_2: begin mul_a = ni_reg; mul_b = 34'(mr_reg); end
                pzfr_pkg::STEP_3: begin mul_a = nr_reg; mul_b = 34'(mi_reg); end
                pzfr_pkg::STEP_4: begin mul_a = mr_reg; mul_b = 34'(mr_reg); end
                pzfr_pkg::STEP_5: begin mul_a = mi_reg; mul_b = 34'(mi_reg); end
                default: ;
            endcase
        end
    end

    assign mul_p = 65'(mul_a) * 65'(mul_b);
    assign p64   = mul_p[63:0];

    // normalize helpers
    logic [63:0] ur, ui, mmax;
    logic [6:0]  blen;
    logic [6:0]  s0;
    logic [63:0] rm;

    assign ur   = mag64(acc_r_reg);
    assign ui   = mag64(acc_i_reg);
    assign mmax = (ur > ui) ? ur : ui;

    always_comb begin
        blen = '0;
        for (int i = 0; i < 64; i++) begin
            if (mmax[i]) blen = 7'(i + 1);
        end
    end

    assign s0 = blen_reg - 7'd30;
    assign rm = rnd_mag(m_reg, s0);

    // divide and scale
    logic [63:0] num_sel, nrnd, nmag;
    logic        neg_reg;
    logic [63:0] quotient;
    logic        div_done;
    logic [31:0] gmag;
    logic [65:0] uprod;
    logic [63:0] u_reg;
    logic [31:0] res_r_reg, res_i_reg;
    logic        ovf_reg;

    assign num_sel = cmd.part_sel ? acc_i_reg : acc_r_reg;
    assign nrnd    = rnd_sgn(num_sel, 7'd28);
    assign nmag    = mag64(nrnd);
    assign gmag    = gain_reg[31] ? (32'd0 - gain_reg) : gain_reg;
    assign uprod   = 66'(quotient[pzfr_pkg::DSR_W-1:0]) * 66'(gmag);

    pzfr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (nmag << 30),
        .divisor  (den_reg[pzfr_pkg::DSR_W+27:28]),
        .done     (div_done),
        .quotient (quotient)
    );

    logic signed [17:0] sh;
    logic [17:0]        negsh;
    logic [6:0]         rs;
    logic [63:0]        limit, sval, rv;
    logic               sat;
    logic [31:0]        res;

    assign sh    = $signed({{2{en_reg[15]}}, en_reg}) - $signed({{2{exp_reg[15]}}, exp_reg})
                   - 18'sd30;
    assign negsh = 18'd0 - sh;
    assign rs    = (negsh > 18'd64) ? 7'd64 : negsh[6:0];
    assign limit = neg_reg ? 64'h80000000 : 64'h7FFFFFFF;
    assign rv    = rnd_mag(u_reg, rs);

    always_comb begin
        sat  = 1'b0;
        sval = u_reg;
        if (u_reg != 64'd0) begin
            if (sh > 18'sd0) begin
                if ((sh >= 18'sd32) || (u_reg > (limit >> sh[4:0]))) begin
                    sval = limit;
                    sat  = 1'b1;
                end else begin
                    sval = u_reg << sh[4:0];
                end
            end else if (rv > limit) begin
                sval = limit;
                sat  = 1'b1;
            end else begin
                sval = rv;
            end
        end
        res = neg_reg ? (32'd0 - sval[31:0]) : sval[31:0];
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (cmd.cap_eval) freq_idx_reg <= freq_index;
        if (cmd.omega_mul) fk_reg <= 48'(freq_step_reg) * 48'(freq_idx_reg);
        if (cmd.omega_rnd) begin
            if ((|fk_reg[47:29]) || wval[31]) omega_reg <= 32'h7FFFFFFF;
            else omega_reg <= wval;
        end
        if (cmd.save_num) begin
            nr_reg <= mr_reg;
            ni_reg <= mi_reg;
            en_reg <= exp_reg;
        end
        if (cmd.fac_load) begin
            fr_reg <= $signed(34'd0 - {{2{rd_sel[31]}}, rd_sel[31:0]});
            fi_reg <= $signed({2'b00, omega_reg} - {{2{rd_sel[63]}}, rd_sel[63:32]});
        end
        if (cmd.mac_en) begin
            if (!cmd.mac_div) begin
                unique case (cmd.mac_step)
                    pzfr_pkg::STEP_0: acc_r_reg <= p64;
                    pzfr_pkg::STEP_1: acc_r_reg <= acc_r_reg - p64;
                    pzfr_pkg::STEP_2: acc_i_reg <= p64;
                    pzfr_pkg::STEP_3: acc_i_reg <= acc_i_reg + p64;
                    default: ;
                endcase
            end else begin
                unique case (cmd.mac_step)
                    pzfr_pkg::STEP_0: acc_r_reg <= p64;
                    pzfr_pkg::STEP_1: acc_r_reg <= acc_r_reg + p64;
                    pzfr_pkg::STEP_2: acc_i_reg <= p64;
                    pzfr_pkg::STEP_3: acc_i_reg <= acc_i_reg - p64;
                    pzfr_pkg::STEP_4: den_reg   <= p64;
                    pzfr_pkg::STEP_5: den_reg   <= den_reg + p64;
                    default: ;
                endcase
            end
        end
        if (cmd.norm_len) begin
            m_reg    <= mmax;
            blen_reg <= blen;
        end
        if (cmd.norm_calc) begin
            nzero_reg <= (blen_reg == 7'd0);
            if (blen_reg > 7'd30) begin
                right_reg <= 1'b1;
                s_reg     <= (rm >= (64'd1 << 30)) ? (s0 + 7'd1) : s0;
            end else begin
                right_reg <= 1'b0;
                s_reg     <= 7'd30 - blen_reg;
            end
        end
        if (cmd.div_start) neg_reg <= num_sel[63] ^ gain_reg[31];
        if (cmd.scale_mul) u_reg <= uprod[63:0];
        if (cmd.scale_sat) begin
            if (cmd.part_sel) res_i_reg <= res;
            else res_r_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prod_init) begin
            mr_reg  <= 31'sh20000000;
            mi_reg  <= '0;
            exp_reg <= 16'hFFE3;
        end else if (cmd.norm_apply) begin
            if (nzero_reg) begin
                mr_reg  <= '0;
                mi_reg  <= '0;
                exp_reg <= '0;
            end else if (right_reg) begin
                mr_reg  <= $signed(31'(rnd_sgn(acc_r_reg, s_reg)));
                mi_reg  <= $signed(31'(rnd_sgn(acc_i_reg, s_reg)));
                exp_reg <= exp_reg - 16'd16 + 16'(s_reg);
            end else begin
                mr_reg  <= $signed(31'(acc_r_reg << s_reg));
                mi_reg  <= $signed(31'(acc_i_reg << s_reg));
                exp_reg <= exp_reg - 16'd16 - 16'(s_reg);
            end
        end
    end

    // control-side registers
    logic                         out_valid_reg;
    logic [pzfr_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [pzfr_pkg::M_TUSER_W-1:0] out_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.prod_init) cnt_reg <= '0;
            else if (cmd.norm_apply) cnt_reg <= cnt_reg + pzfr_pkg::CNT_W'(1);
            if (cmd.cap_eval) ovf_reg <= 1'b0;
            else if (cmd.scale_sat) ovf_reg <= ovf_reg | sat;
            if (cmd.out_load) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (cmd.out_zden) begin
                out_data_reg <= '0;
                out_user_reg <= 2'b10;
            end else begin
                out_data_reg <= {res_i_reg, res_r_reg};
                out_user_reg <= {1'b0, ovf_reg};
            end
        end
    end

    assign stat.cnt_done = cmd.tab_sel ? (cnt_reg >= np_lim) : (cnt_reg >= nz_lim);
    assign stat.zero_den = (mr_reg == 31'sd0) && (mi_reg == 31'sd0);
    assign stat.div_done = div_done;
    assign stat.out_free = ~out_valid_reg | m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

[src/pole_zero_frequency_response.sv]
// Pole-zero frequency response evaluator.
// Input stream (s_*): tuser carries the opcode. A load zero or load pole
// transaction writes one complex root into its table.
// An evaluate transaction forms gain * prod(jw - zero) / prod(jw - pole)
// and returns one result on the output stream (m_*): real and imaginary
// parts in tdata, overflow and zero-denominator flags in tuser.
// Configuration: cfg_wr_en writes register cfg_index (0 gain, 1 freq_step,
// 2 num_zeros, 3 num_poles) from cfg_wr_data.
// Each of the nz zeros and np poles in use passes through the shared
// complex multiplier and normalizer, and the two quotients are formed
// one after the other in the bit-serial divider.
// One item is worked at a time; s_tready is high only while the engine
// is idle. A finished result waits in the output register; the next item
// is accepted meanwhile, and a new result holds until m_tready frees it.
// Reset (aresetn low, synchronous) restores gain and freq_step to 1.0,
// clears both root counts and drops any pending result. Table contents
// are kept undefined until written.
module pole_zero_frequency_response (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // entry_index, root_real, root_imag, freq_index, zero pad
    input  logic [pzfr_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode
    input  logic [pzfr_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // resp_real, resp_imag
    output logic [pzfr_pkg::M_TDATA_W-1:0]   m_tdata,
    // overflow, zero_denominator
    output logic [pzfr_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                             cfg_wr_en,
    input  logic [pzfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pzfr_pkg::CFG_DAT_W-1:0]   cfg_wr_data
);

    pzfr_pkg::pzfr_cmd_t  cmd;
    pzfr_pkg::pzfr_stat_t stat;

    pzfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .opcode   (pzfr_pkg::pzfr_op_t'(s_tuser)),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    pzfr_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .entry_index (s_tdata[4:0]),
        .root_real   (s_tdata[36:5]),
        .root_imag   (s_tdata[68:37]),
        .freq_index  (s_tdata[84:69]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
